FILE: design/cpd_pkg.sv
package cpd_pkg;

    // pipeline depths
    localparam int SQ_STAGES  = 32;   // one root bit per stage
    localparam int DIV_STAGES = 31;   // one quotient bit per stage

    // register indexes of the configuration channel
    typedef enum logic [1:0] {
        REG_CENTER_X        = 2'd0,
        REG_CENTER_Z        = 2'd1,
        REG_FIELD_DIAMETER  = 2'd2,
        REG_OBJECT_DIAMETER = 2'd3
    } cpd_reg_t;

    // one input transaction
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
    } cpd_in_t;

    // one result transaction
    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_z;
        logic               moved;
    } cpd_out_t;

    // per-item data carried alongside the arithmetic
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] pz;
        logic        negx;
        logic        negz;
        logic        outside;
        logic [30:0] sx;
        logic [30:0] sz;
    } cpd_side_t;

endpackage

FILE: design/clamp_point_to_disc.sv
// Channel   Handshake                 Payload
// -------   -----------------------   ----------------------------------
// input     start / busy              item   : pos_x, pos_z
// result    done (one-cycle strobe)   result : new_x, new_z, moved
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One transaction accepted every cycle; busy is never raised.
// Each result is strobed on done after it passes through 6 set-up stages
// (capture, offsets, magnitudes, squares, sum, compare), 32 square-root stages,
// 2 numerator stages, 31 divider stages and one output stage.
// Reset clears the valid bits of every stage and loads the register defaults.
// No stall anywhere: the receiver takes each result in its strobe cycle.
module clamp_point_to_disc
    import cpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cpd_in_t     item,
    output logic        done,
    output cpd_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers
    logic signed [31:0] center_x_reg, center_z_reg;
    logic [30:0]        field_d_reg, object_d_reg;
    logic [29:0]        border_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_z_reg <= '0;
            field_d_reg  <= 31'd655360;
            object_d_reg <= 31'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cpd_reg_t'(cfg_index))
                REG_CENTER_X:        center_x_reg <= cfg_data;
                REG_CENTER_Z:        center_z_reg <= cfg_data;
                REG_FIELD_DIAMETER:  field_d_reg  <= cfg_data[30:0];
                REG_OBJECT_DIAMETER: object_d_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // border radius, saturated at zero
    logic [31:0] diam_diff;
    assign diam_diff = {1'b0, field_d_reg} - {1'b0, object_d_reg};

    always_ff @(posedge clk)
    begin
        border_reg <= diam_diff[31] ? '0 : diam_diff[30:1];
    end

    // stage 1: capture
    logic        v1_reg;
    logic [31:0] px1_reg, pz1_reg;

    // stage 2: offsets from centre
    logic        v2_reg;
    logic [32:0] dx2_reg, dz2_reg;
    logic [31:0] px2_reg, pz2_reg;

    // stage 3: magnitudes, range pre-shift
    logic        v3_reg, big3_reg;
    cpd_side_t   sd3_reg;

    // stage 4: squares
    logic        v4_reg, big4_reg;
    cpd_side_t   sd4_reg;
    logic [61:0] sqx4_reg, sqz4_reg;
    logic [59:0] bsq4_reg;

    // stage 5: sum of squares
    logic        v5_reg, big5_reg;
    cpd_side_t   sd5_reg;
    logic [62:0] sum5_reg;
    logic [59:0] bsq5_reg;

    // stage 6: outside decision
    logic        v6_reg;
    cpd_side_t   sd6_reg;
    logic [62:0] sum6_reg;

    logic [32:0] dx2_next, dz2_next;
    logic [31:0] ax3_next, az3_next;
    logic        shift3_next;
    cpd_side_t   sd3_next, sd6_next;

    assign dx2_next = 33'($signed(px1_reg)) - 33'(center_x_reg);
    assign dz2_next = 33'($signed(pz1_reg)) - 33'(center_z_reg);

    always_comb
    begin
        ax3_next = dx2_reg[32] ? 32'(-dx2_reg) : dx2_reg[31:0];
        az3_next = dz2_reg[32] ? 32'(-dz2_reg) : dz2_reg[31:0];
        shift3_next     = ax3_next[31] || az3_next[31];
        sd3_next.px     = px2_reg;
        sd3_next.pz     = pz2_reg;
        sd3_next.negx   = dx2_reg[32];
        sd3_next.negz   = dz2_reg[32];
        sd3_next.outside = 1'b0;
        sd3_next.sx     = shift3_next ? ax3_next[31:1] : ax3_next[30:0];
        sd3_next.sz     = shift3_next ? az3_next[31:1] : az3_next[30:0];
    end

    always_comb
    begin
        sd6_next         = sd5_reg;
        sd6_next.outside = big5_reg || (sum5_reg > {3'b0, bsq5_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px1_reg  <= item.pos_x;
        pz1_reg  <= item.pos_z;
        dx2_reg  <= dx2_next;
        dz2_reg  <= dz2_next;
        px2_reg  <= px1_reg;
        pz2_reg  <= pz1_reg;
        sd3_reg  <= sd3_next;
        big3_reg <= (ax3_next > {2'b0, border_reg}) || (az3_next > {2'b0, border_reg});
        sd4_reg  <= sd3_reg;
        big4_reg <= big3_reg;
        sqx4_reg <= 62'(sd3_reg.sx) * 62'(sd3_reg.sx);
        sqz4_reg <= 62'(sd3_reg.sz) * 62'(sd3_reg.sz);
        bsq4_reg <= 60'(border_reg) * 60'(border_reg);
        sd5_reg  <= sd4_reg;
        big5_reg <= big4_reg;
        sum5_reg <= {1'b0, sqx4_reg} + {1'b0, sqz4_reg};
        bsq5_reg <= bsq4_reg;
        sd6_reg  <= sd6_next;
        sum6_reg <= sum5_reg;
    end

    // square root of the (shifted) squared distance
    logic        vq_valid;
    cpd_side_t   vq_side;
    logic [31:0] vq_len;

    cpd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_side   (sd6_reg),
        .in_n      ({1'b0, sum6_reg}),
        .out_valid (vq_valid),
        .out_side  (vq_side),
        .out_len   (vq_len)
    );

    // stage A: numerators a * border
    logic        va_reg;
    cpd_side_t   sda_reg;
    logic [31:0] lena_reg;
    logic [60:0] nxa_reg, nza_reg;

    // stage B: add half divisor for rounding
    logic        vb_reg;
    cpd_side_t   sdb_reg;
    logic [31:0] lenb_reg;
    logic [61:0] nxb_reg, nzb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= vq_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sda_reg  <= vq_side;
        lena_reg <= (vq_len == '0) ? 32'd1 : vq_len;
        nxa_reg  <= 61'(vq_side.sx) * 61'(border_reg);
        nza_reg  <= 61'(vq_side.sz) * 61'(border_reg);
        sdb_reg  <= sda_reg;
        lenb_reg <= lena_reg;
        nxb_reg  <= {1'b0, nxa_reg} + 62'(lena_reg >> 1);
        nzb_reg  <= {1'b0, nza_reg} + 62'(lena_reg >> 1);
    end

    // rounded offsets along the ray
    logic        vd_valid;
    cpd_side_t   vd_side;
    logic [30:0] vd_qx, vd_qz;

    cpd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vb_reg),
        .in_side   (sdb_reg),
        .in_len    (lenb_reg),
        .in_num_x  (nxb_reg),
        .in_num_z  (nzb_reg),
        .out_valid (vd_valid),
        .out_side  (vd_side),
        .out_qx    (vd_qx),
        .out_qz    (vd_qz)
    );

    // output stage: signed offset, add to centre, saturate
    logic [33:0] offx, offz, sumx, sumz;
    logic [31:0] satx, satz;
    logic        done_reg;
    cpd_out_t    result_reg;
    cpd_out_t    result_next;

    always_comb
    begin
        offx = vd_side.negx ? -34'(vd_qx) : 34'(vd_qx);
        offz = vd_side.negz ? -34'(vd_qz) : 34'(vd_qz);
        sumx = 34'(center_x_reg) + offx;
        sumz = 34'(center_z_reg) + offz;
        if (!sumx[33] && sumx[32:31] != 2'b00)
            satx = 32'h7FFF_FFFF;
        else if (sumx[33] && sumx[32:31] != 2'b11)
            satx = 32'h8000_0000;
        else
            satx = sumx[31:0];
        if (!sumz[33] && sumz[32:31] != 2'b00)
            satz = 32'h7FFF_FFFF;
        else if (sumz[33] && sumz[32:31] != 2'b11)
            satz = 32'h8000_0000;
        else
            satz = sumz[31:0];
        result_next.new_x = vd_side.outside ? satx : vd_side.px;
        result_next.new_z = vd_side.outside ? satz : vd_side.pz;
        result_next.moved = vd_side.outside;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vd_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // offsets never exceed the border radius
    a_qx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vd_valid && vd_side.outside |-> 32'(vd_qx) <= 32'(border_reg))
        else $error("x offset beyond border");

    a_qz_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vd_valid && vd_side.outside |-> 32'(vd_qz) <= 32'(border_reg))
        else $error("z offset beyond border");

    // root is at least as long as the x component
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg |-> (66'(lena_reg) * 66'(lena_reg) >=
                    66'(sda_reg.sx) * 66'(sda_reg.sx)))
        else $error("root shorter than x component");

    // a point that is not moved leaves the block with its x unchanged
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        vd_valid && !vd_side.outside |=> done && result.new_x == $past(vd_side.px))
        else $error("unmoved point altered");

endmodule

FILE: design/cpd_sqrt.sv
module cpd_sqrt
    import cpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cpd_side_t   in_side,
    input  logic [63:0] in_n,
    output logic        out_valid,
    output cpd_side_t   out_side,
    output logic [31:0] out_len
);

    logic [63:0] n_reg    [SQ_STAGES];
    logic [63:0] res_reg  [SQ_STAGES];
    cpd_side_t   side_reg [SQ_STAGES];
    logic        valid_reg[SQ_STAGES];

    // one bit of the root per stage, test bit walking down by two
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_in, res_in, n_next, res_next, trial;
        logic        valid_in;
        cpd_side_t   side_in;

        if (k == 0) begin : g_first
            assign n_in     = in_n;
            assign res_in   = '0;
            assign valid_in = in_valid;
            assign side_in  = in_side;
        end else begin : g_rest
            assign n_in     = n_reg[k-1];
            assign res_in   = res_reg[k-1];
            assign valid_in = valid_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (n_in >= trial)
            begin
                n_next   = n_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                n_next   = n_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            n_reg[k]    <= n_next;
            res_reg[k]  <= res_next;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];
    assign out_len   = res_reg[SQ_STAGES-1][31:0];

endmodule

FILE: design/cpd_div.sv
module cpd_div
    import cpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cpd_side_t   in_side,
    input  logic [31:0] in_len,
    input  logic [61:0] in_num_x,
    input  logic [61:0] in_num_z,
    output logic        out_valid,
    output cpd_side_t   out_side,
    output logic [30:0] out_qx,
    output logic [30:0] out_qz
);

    logic [62:0] rx_reg   [DIV_STAGES];
    logic [62:0] rz_reg   [DIV_STAGES];
    logic [30:0] qx_reg   [DIV_STAGES];
    logic [30:0] qz_reg   [DIV_STAGES];
    logic [31:0] len_reg  [DIV_STAGES];
    cpd_side_t   side_reg [DIV_STAGES];
    logic        valid_reg[DIV_STAGES];

    // restoring division, both lanes share the divisor, MSB of quotient first
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int SH = DIV_STAGES - 1 - k;
        logic [62:0] rx_in, rz_in, rx_next, rz_next, dsr;
        logic [30:0] qx_in, qz_in, qx_next, qz_next;
        logic [31:0] len_in;
        logic        valid_in;
        cpd_side_t   side_in;

        if (k == 0) begin : g_first
            assign rx_in    = {1'b0, in_num_x};
            assign rz_in    = {1'b0, in_num_z};
            assign qx_in    = '0;
            assign qz_in    = '0;
            assign len_in   = in_len;
            assign valid_in = in_valid;
            assign side_in  = in_side;
        end else begin : g_rest
            assign rx_in    = rx_reg[k-1];
            assign rz_in    = rz_reg[k-1];
            assign qx_in    = qx_reg[k-1];
            assign qz_in    = qz_reg[k-1];
            assign len_in   = len_reg[k-1];
            assign valid_in = valid_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        always_comb
        begin
            dsr     = 63'(len_in) << SH;
            rx_next = rx_in;
            rz_next = rz_in;
            qx_next = qx_in;
            qz_next = qz_in;
            if (rx_in >= dsr)
            begin
                rx_next     = rx_in - dsr;
                qx_next[SH] = 1'b1;
            end
            if (rz_in >= dsr)
            begin
                rz_next     = rz_in - dsr;
                qz_next[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            rx_reg[k]   <= rx_next;
            rz_reg[k]   <= rz_next;
            qx_reg[k]   <= qx_next;
            qz_reg[k]   <= qz_next;
            len_reg[k]  <= len_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign out_qx    = qx_reg[DIV_STAGES-1];
    assign out_qz    = qz_reg[DIV_STAGES-1];

endmodule

FILE: bench/clamp_point_to_disc_test.sv
module clamp_point_to_disc_test;
    import cpd_pkg::*;

    localparam int LATENCY   = 72;
    localparam int MAX_CYCLE = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cpd_in_t     item;
    logic        done;
    cpd_out_t    result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // local copy of the register file
    logic signed [31:0] ctr_x;
    logic signed [31:0] ctr_z;
    logic [30:0]        fld_diam;
    logic [30:0]        obj_diam;

    cpd_out_t clamped_q[$];
    int       mismatches;
    int       cycle_count;
    int       send_idle_pct;

    clamp_point_to_disc dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // bit-serial integer square root
    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // expected clamp of one point against the current field
    function automatic cpd_out_t clamp_expect(input cpd_in_t p);
        cpd_out_t           r;
        logic signed [63:0] dx;
        logic signed [63:0] dz;
        logic signed [63:0] diff;
        logic [63:0]        border;
        logic [63:0]        ax;
        logic [63:0]        az;
        logic [63:0]        len;
        logic [63:0]        ox;
        logic [63:0]        oz;
        logic               outside;
        dx   = 64'(p.pos_x) - 64'(ctr_x);
        dz   = 64'(p.pos_z) - 64'(ctr_z);
        diff = $signed({33'd0, fld_diam}) - $signed({33'd0, obj_diam});
        border = (diff < 0) ? 64'd0 : (diff >>> 1);
        ax = (dx < 0) ? -dx : dx;
        az = (dz < 0) ? -dz : dz;
        if (ax > border || az > border)
            outside = 1'b1;
        else
            outside = ax * ax + az * az > border * border;
        r.new_x = p.pos_x;
        r.new_z = p.pos_z;
        r.moved = outside;
        if (outside)
        begin
            if (ax >= 64'h8000_0000 || az >= 64'h8000_0000)
            begin
                ax = ax >> 1;
                az = az >> 1;
            end
            len = root_floor(ax * ax + az * az);
            if (len == 0)
                len = 1;
            ox = (ax * border + (len >> 1)) / len;
            oz = (az * border + (len >> 1)) / len;
            r.new_x = sat_s32(64'(ctr_x) + ((dx < 0) ? -$signed(ox) : $signed(ox)));
            r.new_z = sat_s32(64'(ctr_z) + ((dz < 0) ? -$signed(oz) : $signed(oz)));
        end
        return r;
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLE)
        begin
            $display("clamp_point_to_disc_test failed");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (clamped_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                cpd_out_t exp_r;
                exp_r = clamped_q.pop_front();
                if (exp_r.new_x !== result.new_x || exp_r.new_z !== result.new_z
                    || exp_r.moved !== result.moved)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h z=%h m=%b, got x=%h z=%h m=%b",
                                 exp_r.new_x, exp_r.new_z, exp_r.moved,
                                 result.new_x, result.new_z, result.moved);
                end
            end
        end
    end

    // one input transaction, with random idle cycles before it
    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] z);
        cpd_in_t p;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        p.pos_x = x;
        p.pos_z = z;
        start <= 1'b1;
        item  <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        clamped_q.push_back(clamp_expect(p));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (clamped_q.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the pipeline empty
    task automatic write_reg(input cpd_reg_t idx, input logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CENTER_X:        ctr_x    = val;
            REG_CENTER_Z:        ctr_z    = val;
            REG_FIELD_DIAMETER:  fld_diam = val[30:0];
            REG_OBJECT_DIAMETER: obj_diam = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_field(input logic [31:0] cx, input logic [31:0] cz,
                             input logic [31:0] fd, input logic [31:0] od);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_FIELD_DIAMETER, fd);
        write_reg(REG_OBJECT_DIAMETER, od);
    endtask

    // extremes, centre, border cases at reset settings
    task automatic test_directed();
        send_idle_pct = 0;
        send_point(0, 0);
        send_point(32'sh7fffffff, 32'sh7fffffff);
        send_point(32'sh80000000, 32'sh80000000);
        send_point(32'sh7fffffff, 32'sh80000000);
        send_point(32'sh00048000, 0);
        send_point(32'sh00048001, 0);
        send_point(0, -32'sh00048001);
        send_point(32'sh00030000, 32'sh00030000);
        send_point(32'sh00040000, 32'sh00040000);
        send_point(-32'sh1, 32'sh12345678);
        // object larger than field: all off-centre points go to the centre
        set_field(32'h0001_0000, 32'hffff_0000, 32'h0001_0000, 32'h7fff_ffff);
        send_point(32'h0001_0000, 32'hffff_0000);
        send_point(0, 0);
        send_point(32'sh80000000, 32'sh7fffffff);
        // extreme centres with a huge field, then with a zero border
        set_field(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        send_point(32'sh80000000, 32'sh7fffffff);
        send_point(32'sh7fffffff, 32'sh80000000);
        send_point(0, 0);
        set_field(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_fffe);
        send_point(32'sh7fffffff, 32'sh80000000);
        send_point(32'sh80000000, 32'sh7fffffff);
        drain();
    endtask

    function automatic logic signed [31:0] near(input logic signed [31:0] c,
                                                 input logic [31:0] span);
        logic signed [63:0] v;
        v = 64'(c) + $signed({32'd0, $urandom_range(span, 0)}) * 2 - $signed({32'd0, span});
        return sat_s32(v);
    endfunction

    // random points, mostly near the border circle
    task automatic test_random(input int count, input int idle);
        logic [31:0] span;
        send_idle_pct = idle;
        for (int i = 0; i < count; i++)
        begin
            span = {1'b0, fld_diam} + 32'd16;
            if ($urandom_range(3, 0) == 0)
                send_point($urandom, $urandom);
            else
                send_point(near(ctr_x, span), near(ctr_z, span));
        end
        drain();
    endtask

    task automatic random_field(input logic [31:0] max_diam);
        set_field($urandom_range(32'h0100_0000, 0) - 32'h0080_0000,
                  $urandom_range(32'h0100_0000, 0) - 32'h0080_0000,
                  $urandom_range(max_diam, 0), $urandom_range(max_diam >> 1, 0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        ctr_x = 0;
        ctr_z = 0;
        fld_diam = 31'd655360;
        obj_diam = 31'd65536;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_field(0, 0, 32'd655360, 32'd65536);
        test_random(400, 0);
        random_field(32'h0040_0000);
        test_random(400, 54);
        random_field(32'h7fff_ffff);
        test_random(400, 7);
        random_field(32'h0001_0000);
        test_random(400, 54);

        drain();
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatches == 0 && clamped_q.size() == 0)
            $display("clamp_point_to_disc_test passed");
        else
            $display("clamp_point_to_disc_test failed");
        $finish;
    end

endmodule

FILE: clamp_point_to_disc.f
design/cpd_pkg.sv
design/cpd_sqrt.sv
design/cpd_div.sv
design/clamp_point_to_disc.sv
bench/clamp_point_to_disc_test.sv
